@@ rtl/rtf_text_extractor_assert.svh @@
// ----------------------------------------------------------------------------
// rtf text extractor assertion macros
// shared concurrent assertion forms, switched off by NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef RTF_TEXT_EXTRACTOR_ASSERT_SVH
`define RTF_TEXT_EXTRACTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define RTE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define RTE_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RTE_ASSERT(name, clk, rst_n, prop, msg)
`define RTE_ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/rte_pkg.sv @@
// ----------------------------------------------------------------------------
// rte_pkg
// types, character codes and keyword tables for the rtf text extractor
// ----------------------------------------------------------------------------
package rte_pkg;

    // default width of the brace depth counters
    localparam int DEPTH_BITS_DEF = 8;

    // scanner modes
    typedef enum logic [2:0] {
        SCAN_PLAIN = 3'd0,
        SCAN_ESC   = 3'd1,
        SCAN_WORD  = 3'd2,
        SCAN_NUM   = 3'd3,
        SCAN_HEX   = 3'd4
    } t_scan_mode;

    // character codes
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // keyword table: fonttbl, colortbl, stylesheet, info, par, line
    localparam int NUM_KW   = 6;
    localparam int NUM_SKIP = 4;
    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    typedef logic [15:0][7:0] t_kw_row;

    // first letter sits in the top byte, rows padded with zeros
    localparam t_kw_row KW_TEXT [NUM_KW] = '{
        {"fonttbl",    72'h0},
        {"colortbl",   64'h0},
        {"stylesheet", 48'h0},
        {"info",       96'h0},
        {"par",       104'h0},
        {"line",       96'h0}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd7, 4'd8, 4'd10, 4'd4, 4'd3, 4'd4};

    // outcome of a finished control word
    typedef struct packed {
        logic skip;
        logic nl;
    } t_eval;

    // up to two results from one input item
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } t_emit;

    // one entry of the result queue
    typedef struct packed {
        logic       last;
        logic [7:0] text_byte;
    } t_out_item;

    localparam int FIFO_DEPTH = 4;
    localparam int OUT_AW     = $clog2(FIFO_DEPTH);

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_numeric(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], CH_MINUS});
    endfunction

    // drop keywords that cannot match with letter b at position pos
    function automatic logic [NUM_KW-1:0] kw_update(input logic [NUM_KW-1:0] hits,
                                                   input logic [3:0] pos,
                                                   input logic [7:0] b);
        logic [NUM_KW-1:0] res;
        res = hits;
        for (int k = 0; k < NUM_KW; k++) begin
            if (pos >= KW_LEN[k] || KW_TEXT[k][4'd15 - pos] != b) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    // first surviving keyword of the right length decides the outcome
    function automatic t_eval word_eval(input logic [NUM_KW-1:0] hits,
                                        input logic [3:0] count);
        logic [NUM_KW-1:0] hit;
        t_eval             res;
        for (int k = 0; k < NUM_KW; k++) begin
            hit[k] = hits[k] && (count == KW_LEN[k]);
        end
        res.skip = |hit[NUM_SKIP-1:0];
        res.nl   = (|hit[NUM_KW-1:NUM_SKIP]) && !res.skip;
        return res;
    endfunction

endpackage

@@ rtl/rte_parse.sv @@
// ----------------------------------------------------------------------------
// rte_parse
// scanner state and per-byte decode: one item per firing, up to two results
// ----------------------------------------------------------------------------
`include "rtf_text_extractor_assert.svh"

module rte_parse #(
    parameter int DEPTH_BITS = rte_pkg::DEPTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_in_byte,
    input  logic          i_doc_end,
    output rte_pkg::t_emit o_emit
);
    import rte_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // scanner registers
    t_scan_mode              r_mode;
    logic [1:0]              r_hex_left;
    logic [3:0]              r_letter_count;
    logic [NUM_KW-1:0]       r_keyword_hits;
    logic [DEPTH_BITS-1:0]   r_group_depth;
    logic                    r_skip_active;
    logic [DEPTH_BITS-1:0]   r_skip_depth;

    // state after the byte, before end of document handling
    t_scan_mode              s_mode;
    logic [1:0]              s_hex_left;
    logic [3:0]              s_letter_count;
    logic [NUM_KW-1:0]       s_keyword_hits;
    logic [DEPTH_BITS-1:0]   s_group_depth;
    logic                    s_skip_active;
    logic [DEPTH_BITS-1:0]   s_skip_depth;

    t_scan_mode              n_mode;
    logic [1:0]              n_hex_left;
    logic [3:0]              n_letter_count;
    logic [NUM_KW-1:0]       n_keyword_hits;
    logic [DEPTH_BITS-1:0]   n_group_depth;
    logic                    n_skip_active;
    logic [DEPTH_BITS-1:0]   n_skip_depth;

    logic    b_alpha;
    logic    b_numeric;
    logic    b_literal;
    logic    b_text;
    logic    in_word;
    logic    word_cont;
    logic    word_end;
    logic    do_plain;
    logic    skip_start;
    t_eval   word_ev;
    t_eval   end_ev;
    logic    nl_a;
    logic    nl_b;
    logic    char_emit;
    t_emit   emit;

    // byte classes
    assign b_alpha   = is_alpha(i_in_byte);
    assign b_numeric = is_numeric(i_in_byte);
    assign b_literal = (i_in_byte inside {CH_BSLASH, CH_LBRACE, CH_RBRACE});
    assign b_text    = !(i_in_byte inside {CH_BSLASH, CH_LBRACE, CH_RBRACE, CH_CR, CH_LF});

    // control word progress
    assign in_word   = (r_mode inside {SCAN_WORD, SCAN_NUM});
    assign word_cont = (r_mode == SCAN_WORD) && b_alpha;
    assign word_end  = in_word && !word_cont && !b_numeric;
    assign word_ev   = word_eval(r_keyword_hits, r_letter_count);

    // byte handled as plain text, in plain mode or after a word ends on it unless it is a space
    assign do_plain   = (!in_word && r_mode != SCAN_ESC && r_mode != SCAN_HEX)
                        || (word_end && i_in_byte != CH_SPACE);
    assign skip_start = (r_mode == SCAN_ESC && i_in_byte == CH_STAR)
                        || (word_end && word_ev.skip);

    // next state for one byte
    always_comb begin
        s_mode         = r_mode;
        s_hex_left     = r_hex_left;
        s_letter_count = r_letter_count;
        s_keyword_hits = r_keyword_hits;
        s_group_depth  = r_group_depth;
        s_skip_active  = r_skip_active;
        s_skip_depth   = r_skip_depth;
        case (r_mode)
            SCAN_HEX: begin
                if (r_hex_left <= 2'd1) begin
                    s_hex_left = 2'd0;
                    s_mode     = SCAN_PLAIN;
                end else begin
                    s_hex_left = r_hex_left - 2'd1;
                end
            end
            SCAN_ESC: begin
                s_mode = SCAN_PLAIN;
                if (i_in_byte == CH_QUOTE) begin
                    s_hex_left = 2'd2;
                    s_mode     = SCAN_HEX;
                end else if (b_alpha) begin
                    s_letter_count = 4'd1;
                    s_keyword_hits = kw_update(KW_ALL, 4'd0, i_in_byte);
                    s_mode         = SCAN_WORD;
                end
            end
            SCAN_WORD, SCAN_NUM: begin
                if (word_cont) begin
                    s_keyword_hits = kw_update(r_keyword_hits, r_letter_count, i_in_byte);
                    if (r_letter_count != 4'hF) begin
                        s_letter_count = r_letter_count + 4'd1;
                    end
                end else if (b_numeric) begin
                    s_mode = SCAN_NUM;
                end else begin
                    s_mode = SCAN_PLAIN;
                end
            end
            default: begin
                s_mode = SCAN_PLAIN;
            end
        endcase

        // suppression keeps the outer depth when nested
        if (skip_start && !r_skip_active) begin
            s_skip_active = 1'b1;
            s_skip_depth  = r_group_depth;
        end

        // braces and backslash in plain text
        if (do_plain) begin
            s_mode = (i_in_byte == CH_BSLASH) ? SCAN_ESC : SCAN_PLAIN;
            if (i_in_byte == CH_LBRACE) begin
                if (r_group_depth != DEPTH_MAX) begin
                    s_group_depth = r_group_depth + 1'b1;
                end
            end else if (i_in_byte == CH_RBRACE) begin
                if (s_skip_active && r_group_depth == s_skip_depth) begin
                    s_skip_active = 1'b0;
                end
                if (r_group_depth != '0) begin
                    s_group_depth = r_group_depth - 1'b1;
                end
            end
        end

        // end of document returns everything to reset
        if (i_doc_end) begin
            n_mode         = SCAN_PLAIN;
            n_hex_left     = 2'd0;
            n_letter_count = 4'd0;
            n_keyword_hits = KW_ALL;
            n_group_depth  = '0;
            n_skip_active  = 1'b0;
            n_skip_depth   = '0;
        end else begin
            n_mode         = s_mode;
            n_hex_left     = s_hex_left;
            n_letter_count = s_letter_count;
            n_keyword_hits = s_keyword_hits;
            n_group_depth  = s_group_depth;
            n_skip_active  = s_skip_active;
            n_skip_depth   = s_skip_depth;
        end
    end

    // results for one byte
    always_comb begin
        end_ev    = word_eval(s_keyword_hits, s_letter_count);
        nl_a      = word_end && word_ev.nl && !r_skip_active;
        char_emit = !s_skip_active
                    && ((do_plain && b_text) || (r_mode == SCAN_ESC && b_literal));
        nl_b      = i_doc_end && (s_mode inside {SCAN_WORD, SCAN_NUM})
                    && end_ev.nl && !s_skip_active;

        emit.count = 2'd0;
        emit.byte0 = i_in_byte;
        emit.byte1 = CH_LF;
        if (nl_a) begin
            emit.byte0 = CH_LF;
            emit.count = 2'd1;
            if (char_emit) begin
                emit.byte1 = i_in_byte;
                emit.count = 2'd2;
            end
        end else if (char_emit) begin
            emit.count = 2'd1;
        end
        if (nl_b) begin
            if (emit.count == 2'd0) begin
                emit.byte0 = CH_LF;
                emit.count = 2'd1;
            end else begin
                emit.byte1 = CH_LF;
                emit.count = 2'd2;
            end
        end
        if (!i_fire) begin
            emit.count = 2'd0;
        end
    end

    assign o_emit = emit;

    // scanner state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= SCAN_PLAIN;
            r_hex_left     <= 2'd0;
            r_letter_count <= 4'd0;
            r_keyword_hits <= KW_ALL;
            r_group_depth  <= '0;
            r_skip_active  <= 1'b0;
            r_skip_depth   <= '0;
        end else if (i_fire) begin
            r_mode         <= n_mode;
            r_hex_left     <= n_hex_left;
            r_letter_count <= n_letter_count;
            r_keyword_hits <= n_keyword_hits;
            r_group_depth  <= n_group_depth;
            r_skip_active  <= n_skip_active;
            r_skip_depth   <= n_skip_depth;
        end
    end

    // checks
    `RTE_ASSERT(a_no_emit_idle, i_clk, i_rst_n, !i_fire |-> (o_emit.count == 2'd0), "result without item")
    `RTE_ASSERT(a_skip_depth, i_clk, i_rst_n, r_skip_active |-> (r_skip_depth <= r_group_depth), "skip depth above group depth")
    `RTE_ASSERT(a_skip_end, i_clk, i_rst_n, $fell(r_skip_active) |-> ($past(i_fire) || !$past(i_rst_n)), "suppression ended without item")

endmodule

@@ rtl/rte_out_fifo.sv @@
// ----------------------------------------------------------------------------
// rte_out_fifo
// four-entry result queue: takes up to two results a cycle, gives one
// ----------------------------------------------------------------------------
`include "rtf_text_extractor_assert.svh"

module rte_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rte_pkg::t_emit i_emit,
    output logic           o_room,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [7:0]     o_m_axis_tdata,
    output logic           o_m_axis_tlast
);
    import rte_pkg::*;

    t_out_item         r_mem [FIFO_DEPTH];
    logic [OUT_AW-1:0] r_wr_ptr;
    logic [OUT_AW-1:0] r_rd_ptr;
    logic [OUT_AW:0]   r_count;
    logic [OUT_AW:0]   n_count;
    logic              pop;
    logic [OUT_AW-1:0] wr_ptr_1;

    assign pop      = o_m_axis_tvalid && i_m_axis_tready;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;
    assign n_count  = r_count + {{(OUT_AW - 1){1'b0}}, i_emit.count} - {{OUT_AW{1'b0}}, pop};

    // room for two results
    assign o_room = (r_count <= (OUT_AW + 1)'(FIFO_DEPTH - 2));

    // result storage, last flag on the final result of an item
    always_ff @(posedge i_clk) begin
        if (i_emit.count != 2'd0) begin
            r_mem[r_wr_ptr] <= '{last: (i_emit.count == 2'd1), text_byte: i_emit.byte0};
        end
        if (i_emit.count == 2'd2) begin
            r_mem[wr_ptr_1] <= '{last: 1'b1, text_byte: i_emit.byte1};
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OUT_AW'(i_emit.count);
            r_rd_ptr <= r_rd_ptr + OUT_AW'(pop);
            r_count  <= n_count;
        end
    end

    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = r_mem[r_rd_ptr].text_byte;
    assign o_m_axis_tlast  = r_mem[r_rd_ptr].last;

    // checks
    `RTE_ASSERT_NEVER(a_overfill, i_clk, i_rst_n, r_count > (OUT_AW + 1)'(FIFO_DEPTH), "result queue overfilled")
    `RTE_ASSERT(a_push_room, i_clk, i_rst_n, (i_emit.count != 2'd0) |-> o_room, "results pushed without room")
    `RTE_ASSERT(a_fill_step, i_clk, i_rst_n, $past(i_rst_n) |-> (r_count <= $past(r_count) + 3'd2), "fill level jumped")

endmodule

@@ rtl/rtf_text_extractor.sv @@
// ----------------------------------------------------------------------------
// rtf_text_extractor
// strips rtf markup from a byte stream and passes on the plain text
// ----------------------------------------------------------------------------
// usage
//   slave channel: one rtf byte per item in s_axis tdata, tlast on the final
//   byte of a document; a pending control word is resolved after that byte
//   and all scanner state returns to its reset value.
//   master channel: one text byte per item, newline is 0x0a; tlast marks the
//   final result caused by an input byte. a byte gives zero, one or two items.
// timing
//   an input item is held in an input register and decoded, once the queue
//   has room for two results, straight into a four-entry result queue, from
//   which the master side takes the results one at a time.
//   one byte per cycle is taken while the queue holds two or fewer results;
//   a byte giving two results hands the master side two items in turn.
// reset and stall
//   synchronous active-low reset empties the queue and the input register
//   and clears brace depth and suppression. when the receiver stalls the
//   queue fills and tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rtf_text_extractor #(
    parameter int DEPTH_BITS = rte_pkg::DEPTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // doc_end
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] text_byte
    output logic       o_m_axis_tlast    // run_end
);
    import rte_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       fire;
    t_emit      emit;

    // decode the held byte when the queue can take both results
    assign fire            = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // scanner
    rte_parse #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_in_byte (r_in_byte),
        .i_doc_end (r_in_last),
        .o_emit    (emit)
    );

    // result queue
    rte_out_fifo u_out_fifo (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_emit          (emit),
        .o_room          (room),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

@@ tb/rtf_text_extractor_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_text_extractor_checker
// watches both item channels of the extractor, works out the plain text that
// every accepted rtf byte should give and compares it with what comes out
// ----------------------------------------------------------------------------
module rtf_text_extractor_checker #(
    parameter int DEPTH_BITS = rte_pkg::DEPTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic       i_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,   // doc_end
    input  logic       i_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    input  logic [7:0] i_m_axis_tdata,   // [7:0] text_byte
    input  logic       i_m_axis_tlast,   // run_end
    output int         o_error_count,
    output int         o_pending
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = {DEPTH_BITS{1'b1}};
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       run_end;
    } t_text_item;

    // words that suppress output come first, then the newline words
    string kw_name [rte_pkg::NUM_KW] = '{"fonttbl", "colortbl", "stylesheet", "info",
                                         "par", "line"};

    t_text_item            text_expected [$];
    logic [7:0]            step_text [$];
    rte_pkg::t_scan_mode   scan;
    logic [1:0]            hex_left;
    logic [3:0]            letters;
    logic [rte_pkg::NUM_KW-1:0] cands;
    logic [DEPTH_BITS-1:0] depth;
    logic [DEPTH_BITS-1:0] skip_lvl;
    logic                  skip_on;
    int                    error_count;
    int                    print_count;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9") || b == rte_pkg::CH_MINUS;
    endfunction

    task automatic report_mismatch(input string msg);
        if (print_count < MAX_PRINTS) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        print_count++;
        error_count++;
    endtask

    task automatic clear_scanner();
        scan     = rte_pkg::SCAN_PLAIN;
        hex_left = '0;
        letters  = '0;
        cands    = '1;
        depth    = '0;
        skip_on  = 1'b0;
        skip_lvl = '0;
    endtask

    // at most two text bytes come out of one input item
    task automatic emit(input logic [7:0] b);
        if (step_text.size() < 2) begin
            step_text.push_back(b);
        end
    endtask

    // an inner suppressing word keeps the outer depth
    task automatic open_skip();
        if (!skip_on) begin
            skip_on  = 1'b1;
            skip_lvl = depth;
        end
    endtask

    task automatic take_letter(input logic [7:0] b);
        for (int k = 0; k < rte_pkg::NUM_KW; k++) begin
            if (letters >= kw_name[k].len() || kw_name[k][letters] != b) begin
                cands[k] = 1'b0;
            end
        end
        if (letters != 4'hF) begin
            letters = letters + 4'd1;
        end
    endtask

    // first surviving word of matching length decides
    task automatic close_word();
        logic found;
        found = 1'b0;
        for (int k = 0; k < rte_pkg::NUM_KW; k++) begin
            if (!found && cands[k] && letters == kw_name[k].len()) begin
                found = 1'b1;
                if (k < rte_pkg::NUM_SKIP) begin
                    open_skip();
                end else if (!skip_on) begin
                    emit(rte_pkg::CH_LF);
                end
            end
        end
    endtask

    task automatic plain_char(input logic [7:0] b);
        scan = rte_pkg::SCAN_PLAIN;
        if (b == rte_pkg::CH_LBRACE) begin
            if (depth != DEPTH_TOP) begin
                depth = depth + 1'b1;
            end
        end else if (b == rte_pkg::CH_RBRACE) begin
            if (skip_on && depth == skip_lvl) begin
                skip_on = 1'b0;
            end
            if (depth != '0) begin
                depth = depth - 1'b1;
            end
        end else if (b == rte_pkg::CH_BSLASH) begin
            scan = rte_pkg::SCAN_ESC;
        end else if (b == rte_pkg::CH_CR || b == rte_pkg::CH_LF) begin
            // raw line breaks vanish
        end else if (!skip_on) begin
            emit(b);
        end
    endtask

    task automatic predict_text(input logic [7:0] b, input logic doc_end);
        t_text_item ti;
        step_text.delete();
        case (scan)
            rte_pkg::SCAN_HEX: begin
                if (hex_left <= 2'd1) begin
                    hex_left = '0;
                    scan     = rte_pkg::SCAN_PLAIN;
                end else begin
                    hex_left = hex_left - 2'd1;
                end
            end
            rte_pkg::SCAN_ESC: begin
                if (b == rte_pkg::CH_BSLASH || b == rte_pkg::CH_LBRACE ||
                    b == rte_pkg::CH_RBRACE) begin
                    if (!skip_on) begin
                        emit(b);
                    end
                    scan = rte_pkg::SCAN_PLAIN;
                end else if (b == rte_pkg::CH_QUOTE) begin
                    hex_left = 2'd2;
                    scan     = rte_pkg::SCAN_HEX;
                end else if (is_letter(b)) begin
                    letters = '0;
                    cands   = '1;
                    take_letter(b);
                    scan = rte_pkg::SCAN_WORD;
                end else begin
                    if (b == rte_pkg::CH_STAR) begin
                        open_skip();
                    end
                    scan = rte_pkg::SCAN_PLAIN;
                end
            end
            rte_pkg::SCAN_WORD, rte_pkg::SCAN_NUM: begin
                if (scan == rte_pkg::SCAN_WORD && is_letter(b)) begin
                    take_letter(b);
                end else if (is_digit(b)) begin
                    scan = rte_pkg::SCAN_NUM;
                end else if (b == rte_pkg::CH_SPACE) begin
                    close_word();
                    scan = rte_pkg::SCAN_PLAIN;
                end else begin
                    // word resolved first, then the byte itself
                    close_word();
                    plain_char(b);
                end
            end
            default: begin
                plain_char(b);
            end
        endcase

        // end of document resolves a pending word and starts afresh
        if (doc_end) begin
            if (scan == rte_pkg::SCAN_WORD || scan == rte_pkg::SCAN_NUM) begin
                close_word();
            end
            clear_scanner();
        end

        foreach (step_text[i]) begin
            ti.text_byte = step_text[i];
            ti.run_end   = (i == step_text.size() - 1);
            text_expected.push_back(ti);
        end
    endtask

    // accept, predict and compare on every edge
    always @(posedge i_clk) begin
        t_text_item want;
        if (!i_rst_n) begin
            clear_scanner();
            text_expected.delete();
            error_count = 0;
            print_count = 0;
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_text(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (text_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected text item %02h last %b",
                                              i_m_axis_tdata, i_m_axis_tlast));
                end else begin
                    want = text_expected.pop_front();
                    if (i_m_axis_tdata !== want.text_byte) begin
                        report_mismatch($sformatf("text_byte %02h, expected %02h",
                                                  i_m_axis_tdata, want.text_byte));
                    end
                    if (i_m_axis_tlast !== want.run_end) begin
                        report_mismatch($sformatf("run_end %b, expected %b on byte %02h",
                                                  i_m_axis_tlast, want.run_end,
                                                  want.text_byte));
                    end
                end
            end
        end
        o_error_count <= error_count;
        o_pending     <= text_expected.size();
    end

endmodule

@@ tb/rtf_text_extractor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtf_text_extractor_tb
// feeds rtf documents into the extractor, first a short hand-written one
// covering the corner cases, then random documents built from text, escapes,
// hex escapes, control words and groups, plus one that drives the brace
// depth past its maximum; both sides idle at random and the checker judges
// ----------------------------------------------------------------------------
module rtf_text_extractor_tb;

    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 900;
    localparam int IDLE_PCT     = 12;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       steady;
    logic       depth_done;
    int         error_count;
    int         pending;
    int         sent;
    logic [7:0] doc_bytes [$];

    string word_pool [17] = '{"fonttbl", "colortbl", "stylesheet", "info", "par", "line",
                              "pa", "pard", "lines", "infoo", "f", "fonttb", "colortb",
                              "stylesheets", "b", "i", "u"};

    rtf_text_extractor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    rtf_text_extractor_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .o_error_count   (error_count),
        .o_pending       (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stalls at random outside the steady stretch
    always @(posedge i_clk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // one item on the slave side, with random gaps before it
    task automatic send_item(input logic [7:0] b, input logic doc_end);
        logic quiet;
        quiet = (sent >= QUIET_FROM && sent < QUIET_TO);
        steady <= quiet;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= doc_end;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            doc_bytes.push_back(s[i]);
        end
    endtask

    // document end on the tail and, for random documents, now and then inside
    task automatic send_queue(input logic stray_ends);
        logic last;
        foreach (doc_bytes[i]) begin
            last = (i == doc_bytes.size() - 1) || (stray_ends && $urandom_range(79) == 0);
            send_item(doc_bytes[i], last);
        end
        doc_bytes.delete();
    endtask

    // ordinary text character, never one of the markup bytes
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h7E, 8'h20));
        if (c == rte_pkg::CH_BSLASH || c == rte_pkg::CH_LBRACE || c == rte_pkg::CH_RBRACE) begin
            c = "e";
        end
        return c;
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] c;
        c = 8'($urandom_range("z", "a"));
        if ($urandom_range(3) == 0) begin
            c = c - 8'h20;
        end
        return c;
    endfunction

    task automatic push_control_word();
        int len;
        if ($urandom_range(9) < 6) begin
            push_text({"\\", word_pool[$urandom_range(16)]});
        end else begin
            // long words drive the letter count into saturation
            len = $urandom_range(3) == 0 ? $urandom_range(20, 14) : $urandom_range(6, 1);
            doc_bytes.push_back(rte_pkg::CH_BSLASH);
            repeat (len) doc_bytes.push_back(any_letter());
        end
        if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(4, 1)) begin
                doc_bytes.push_back($urandom_range(4) == 0 ? rte_pkg::CH_MINUS
                                                          : 8'($urandom_range("9", "0")));
            end
        end
        case ($urandom_range(9))
            0, 1, 2, 3: doc_bytes.push_back(rte_pkg::CH_SPACE);
            4, 5, 6:    ;
            7:          doc_bytes.push_back(rte_pkg::CH_RBRACE);
            8:          doc_bytes.push_back(rte_pkg::CH_LBRACE);
            default:    doc_bytes.push_back(text_char());
        endcase
    endtask

    task automatic push_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            repeat ($urandom_range(5, 1)) doc_bytes.push_back(text_char());
        end else if (pick < 38) begin
            doc_bytes.push_back(8'($urandom_range(255)));
        end else if (pick < 43) begin
            doc_bytes.push_back($urandom_range(1) ? rte_pkg::CH_CR : rte_pkg::CH_LF);
        end else if (pick < 51) begin
            doc_bytes.push_back(rte_pkg::CH_BSLASH);
            case ($urandom_range(2))
                0:       doc_bytes.push_back(rte_pkg::CH_BSLASH);
                1:       doc_bytes.push_back(rte_pkg::CH_LBRACE);
                default: doc_bytes.push_back(rte_pkg::CH_RBRACE);
            endcase
        end else if (pick < 57) begin
            doc_bytes.push_back(rte_pkg::CH_BSLASH);
            doc_bytes.push_back(rte_pkg::CH_QUOTE);
            doc_bytes.push_back(8'($urandom_range(255)));
            doc_bytes.push_back(8'($urandom_range(255)));
        end else if (pick < 78) begin
            push_control_word();
        end else if (pick < 83) begin
            doc_bytes.push_back(rte_pkg::CH_BSLASH);
            doc_bytes.push_back(rte_pkg::CH_STAR);
        end else if (pick < 88) begin
            // backslash before an arbitrary byte
            doc_bytes.push_back(rte_pkg::CH_BSLASH);
            doc_bytes.push_back(8'($urandom_range(255)));
        end else if (pick < 94) begin
            doc_bytes.push_back(rte_pkg::CH_LBRACE);
        end else begin
            doc_bytes.push_back(rte_pkg::CH_RBRACE);
        end
    endtask

    // stimulus
    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        steady   <= 1'b0;
        sent = 0;
        depth_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // closing brace at depth zero, byte extremes, brace inside a hex escape,
        // other control symbol, nested suppression, word ended by a comma,
        // and a word left pending at the end of the document
        push_text("}");
        doc_bytes.push_back(8'h00);
        doc_bytes.push_back(8'hFF);
        push_text("\\'}A\\~{\\*{\\info}}\\par,\\line");
        send_queue(1'b0);

        // random documents, one of them pushing the depth past its maximum
        while (sent < RANDOM_ITEMS) begin
            if (!depth_done && sent >= RANDOM_ITEMS / 2) begin
                repeat ((1 << rte_pkg::DEPTH_BITS_DEF) + 1) doc_bytes.push_back(rte_pkg::CH_LBRACE);
                push_text("\\info {x}ok");
                depth_done = 1'b1;
                send_queue(1'b0);
            end else begin
                repeat ($urandom_range(80, 10)) push_token();
                doc_bytes.push_back(8'($urandom_range(255)));
                send_queue(1'b1);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        steady   <= 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rte_pkg.sv
rtl/rte_parse.sv
rtl/rte_out_fifo.sv
rtl/rtf_text_extractor.sv
tb/rtf_text_extractor_checker.sv
tb/rtf_text_extractor_tb.sv
